### rtl/clwm_pkg.sv
// package: widths, constants, register indexes and shared types of the load monitor
package clwm_pkg;
    localparam int unsigned HistDepthDef = 8;
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_CORE0_WIN = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_CORE1_WIN = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SYS_WIN   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MIN_SAMP  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_THRESH    = 3'd4;

    // divider operand selects
    localparam logic [2:0] DIV_LOAD0 = 3'd0;
    localparam logic [2:0] DIV_LOAD1 = 3'd1;
    localparam logic [2:0] DIV_SYS   = 3'd2;
    localparam logic [2:0] DIV_AVG0  = 3'd3;
    localparam logic [2:0] DIV_AVG1  = 3'd4;
    localparam logic [2:0] DIV_AVGS  = 3'd5;
    localparam logic [2:0] DIV_HIST  = 3'd6;

    typedef struct packed {
        logic [31:0] total_run_time;
        logic [31:0] idle_count_core0;
        logic [31:0] idle_count_core1;
        logic [1:0]  idle_found;
        logic [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic [6:0] c0_load_pct;
        logic [6:0] c1_load_pct;
        logic [6:0] sys_load_pct;
        logic       core0_window_done;
        logic       core1_window_done;
        logic       system_window_done;
        logic [6:0] core0_history_avg;
        logic [6:0] core1_history_avg;
        logic [6:0] system_history_avg;
        logic       core0_overload;
        logic       core1_overload;
        logic       system_overload;
    } t_out_item;

    // datapath commands
    typedef struct packed {
        logic load_item;   // capture item, compute deltas
        logic div_start;   // start a division
        logic [2:0] div_sel; // load, window average or history average operands
        logic [1:0] chan;  // channel for close/hist ops
        logic acc;         // accumulate load samples
        logic close;       // window close check for chan
        logic hist_step;   // add one history entry for chan
        logic hist_clr;    // clear history sum
        logic hist_avg;    // latch history average (after div)
        logic finish;      // commit prev_total
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic baseline;
        logic delta_zero;
        logic close_due;
        logic [7:0] hist_n;
    } t_stat;
endpackage

### rtl/clwm_if.sv
// valid/ready channel interfaces for items and configuration writes
interface clwm_in_if;
    import clwm_pkg::*;
    logic valid;
    logic ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface clwm_out_if;
    import clwm_pkg::*;
    logic valid;
    logic ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface clwm_cfg_if;
    import clwm_pkg::*;
    logic valid;
    logic ready;
    logic [CfgIdxW-1:0] index;
    logic [31:0] wdata;
    modport source(output valid, output index, output wdata, input ready);
    modport sink(input valid, input index, input wdata, output ready);
endinterface

### rtl/clwm_div.sv
// iterative restoring divider, one quotient bit per cycle
module clwm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [33:0] i_den,
    output logic        o_busy,
    output logic [39:0] o_quo
);
    logic [39:0] r_q, n_q;
    logic [33:0] r_rem, n_rem;
    logic [33:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [34:0] w_trial;

    assign w_trial = {r_rem, r_q[39]} - {1'b0, r_den};
    always_comb begin
        n_q = {r_q[38:0], 1'b0};
        n_rem = {r_rem[32:0], r_q[39]};
        if (!w_trial[34]) begin
            n_rem = w_trial[33:0];
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= 6'd40;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quo = r_q;
endmodule

### rtl/clwm_datapath.sv
// datapath: counters, window accumulators, history memory and result register
module clwm_datapath #(
    parameter int unsigned HISTORY_DEPTH = clwm_pkg::HistDepthDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clwm_pkg::t_cmd      i_cmd,
    input  clwm_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [clwm_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output clwm_pkg::t_stat     o_stat,
    output clwm_pkg::t_out_item o_res
);
    import clwm_pkg::*;
    localparam int unsigned PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned NW = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned HW = $clog2(3 * HISTORY_DEPTH);

    logic [31:0] r_win [3];
    logic [15:0] r_min_samp;
    logic [6:0]  r_thresh;
    logic        r_base_pend;
    logic [31:0] r_prev_total;
    logic [31:0] r_prev_idle [2];
    logic [31:0] r_sum [3];
    logic [31:0] r_cnt [3];
    logic [31:0] r_start [3];
    logic [6:0]  r_now [3];
    logic [2:0]  r_done;
    logic [PW-1:0] r_ptr [3];
    logic [2:0]  r_full;
    logic [6:0]  r_hist [3*HISTORY_DEPTH];
    logic [6:0]  r_havg [3];
    logic [14:0] r_hsum;
    logic [PW-1:0] r_hidx;
    logic [31:0] r_delta;
    logic [31:0] r_id [2];
    logic [32:0] r_isum;
    logic [31:0] r_time;
    logic [31:0] r_total;

    logic        w_busy;
    logic [39:0] w_quo;
    logic [39:0] w_num;
    logic [33:0] w_den;
    logic [31:0] w_idle [2];
    logic [31:0] w_id [2];
    logic [1:0]  w_ch;
    logic [31:0] w_dur;
    logic [6:0]  w_cap;
    logic [NW-1:0] w_n [3];
    logic [33:0] w_poss;
    logic [33:0] w_idl;
    logic [HW-1:0] w_widx;
    logic [HW-1:0] w_ridx;

    assign w_ch = (i_cmd.chan == 2'd3) ? 2'd2 : i_cmd.chan;
    assign w_idle[0] = i_item.idle_found[0] ? i_item.idle_count_core0 : 32'd0;
    assign w_idle[1] = i_item.idle_found[1] ? i_item.idle_count_core1 : 32'd0;
    assign w_id[0] = w_idle[0] - r_prev_idle[0];
    assign w_id[1] = w_idle[1] - r_prev_idle[1];
    assign w_poss = {1'b0, r_delta, 1'b0};
    assign w_idl = ({1'b0, r_isum} > w_poss) ? w_poss : {1'b0, r_isum};
    assign w_widx = HW'(32'(w_ch) * HISTORY_DEPTH + 32'(r_ptr[w_ch]));
    assign w_ridx = HW'(32'(w_ch) * HISTORY_DEPTH + 32'(r_hidx));

    for (genvar g = 0; g < 3; g++) begin : g_n
        assign w_n[g] = r_full[g] ? NW'(HISTORY_DEPTH) : NW'(r_ptr[g]);
    end

    // numerator and divisor for the shared divider
    always_comb begin
        w_num = '0;
        w_den = 34'd1;
        case (i_cmd.div_sel)
            DIV_LOAD0, DIV_LOAD1: begin
                w_num = ((r_id[i_cmd.div_sel[0]] <= r_delta) ?
                    40'(r_delta - r_id[i_cmd.div_sel[0]]) : 40'd0) * 40'd100;
                w_den = {2'b0, r_delta};
            end
            DIV_SYS: begin
                w_num = 40'(w_poss - w_idl) * 40'd100;
                w_den = w_poss;
            end
            DIV_AVG0, DIV_AVG1, DIV_AVGS: begin
                w_num = {8'd0, r_sum[w_ch]};
                w_den = {2'b0, r_cnt[w_ch]};
            end
            DIV_HIST: begin
                w_num = {25'd0, r_hsum};
                w_den = {{(34-NW){1'b0}}, w_n[w_ch]};
            end
            default: begin
                w_num = '0;
                w_den = 34'd1;
            end
        endcase
    end

    clwm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(w_num), .i_den(w_den), .o_busy(w_busy), .o_quo(w_quo)
    );

    assign w_dur = r_time - r_start[w_ch];
    assign w_cap = (w_quo > 40'd100) ? 7'd100 : w_quo[6:0];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= 32'd600;
            r_win[1] <= 32'd50;
            r_win[2] <= 32'd600;
            r_min_samp <= 16'd1;
            r_thresh <= 7'd80;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CORE0_WIN: r_win[0] <= i_cfg_data;
                CFG_CORE1_WIN: r_win[1] <= i_cfg_data;
                CFG_SYS_WIN:   r_win[2] <= i_cfg_data;
                CFG_MIN_SAMP:  r_min_samp <= i_cfg_data[15:0];
                CFG_THRESH:    r_thresh <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_pend <= 1'b1;
            r_prev_total <= '0;
            r_done <= '0;
            r_full <= '0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
                r_cnt[k] <= '0;
                r_start[k] <= '0;
                r_now[k] <= '0;
                r_ptr[k] <= '0;
                r_havg[k] <= '0;
            end
            for (int k = 0; k < 2; k++) r_prev_idle[k] <= '0;
            for (int k = 0; k < 3*HISTORY_DEPTH; k++) r_hist[k] <= '0;
        end else begin
            if (i_cmd.load_item) begin
                r_total <= i_item.total_run_time;
                r_time <= i_item.time_ms;
                r_delta <= i_item.total_run_time - r_prev_total;
                if (o_stat.baseline) begin
                    if (i_item.idle_found[0]) r_prev_idle[0] <= i_item.idle_count_core0;
                    if (i_item.idle_found[1]) r_prev_idle[1] <= i_item.idle_count_core1;
                    r_base_pend <= 1'b0;
                end else begin
                    r_id[0] <= w_id[0];
                    r_id[1] <= w_id[1];
                    r_isum <= {1'b0, w_id[0]} + {1'b0, w_id[1]};
                    r_prev_idle[0] <= w_idle[0];
                    r_prev_idle[1] <= w_idle[1];
                end
            end
            if (i_cmd.acc) begin
                r_sum[w_ch] <= r_sum[w_ch] + w_quo[31:0];
                r_cnt[w_ch] <= r_cnt[w_ch] + 32'd1;
            end
            if (i_cmd.close) begin
                r_now[w_ch] <= w_cap;
                r_done[w_ch] <= 1'b1;
                r_sum[w_ch] <= '0;
                r_cnt[w_ch] <= '0;
                r_start[w_ch] <= r_time;
                r_hist[w_widx] <= w_cap;
                if (32'(r_ptr[w_ch]) == HISTORY_DEPTH - 1) begin
                    r_ptr[w_ch] <= '0;
                    r_full[w_ch] <= 1'b1;
                end else begin
                    r_ptr[w_ch] <= r_ptr[w_ch] + PW'(1);
                end
            end
            if (i_cmd.hist_avg)
                r_havg[w_ch] <= (w_n[w_ch] == '0) ? 7'd0 : w_quo[6:0];
            if (i_cmd.finish) r_prev_total <= r_total;
        end
    end

    // history summation, one entry per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.hist_clr) begin
            r_hsum <= '0;
            r_hidx <= '0;
        end else if (i_cmd.hist_step) begin
            r_hsum <= r_hsum + 15'(r_hist[w_ridx]);
            r_hidx <= (32'(r_hidx) == HISTORY_DEPTH - 1) ? '0 : r_hidx + PW'(1);
        end
    end

    assign o_stat.div_busy = w_busy;
    assign o_stat.baseline = r_base_pend || (r_prev_total == 32'd0);
    assign o_stat.delta_zero = (r_delta == 32'd0);
    assign o_stat.close_due = (w_dur >= r_win[w_ch]) && (r_cnt[w_ch] != 32'd0) &&
        (r_cnt[w_ch] >= {16'd0, r_min_samp});
    assign o_stat.hist_n = 8'(w_n[w_ch]);

    assign o_res.c0_load_pct = r_now[0];
    assign o_res.c1_load_pct = r_now[1];
    assign o_res.sys_load_pct = r_now[2];
    assign o_res.core0_window_done = r_done[0];
    assign o_res.core1_window_done = r_done[1];
    assign o_res.system_window_done = r_done[2];
    assign o_res.core0_history_avg = r_havg[0];
    assign o_res.core1_history_avg = r_havg[1];
    assign o_res.system_history_avg = r_havg[2];
    assign o_res.core0_overload = r_havg[0] >= r_thresh;
    assign o_res.core1_overload = r_havg[1] >= r_thresh;
    assign o_res.system_overload = r_havg[2] >= r_thresh;
endmodule

### rtl/clwm_ctrl.sv
// controller: sequences load, divide, window close and history steps per item
module clwm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  clwm_pkg::t_stat i_stat,
    output clwm_pkg::t_cmd  o_cmd
);
    import clwm_pkg::*;
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_SDIV  = 4'd2;
    localparam logic [3:0] S_WDIV  = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_CWAIT = 4'd6;
    localparam logic [3:0] S_CLOSE = 4'd7;
    localparam logic [3:0] S_HSUM  = 4'd8;
    localparam logic [3:0] S_HDIV  = 4'd9;
    localparam logic [3:0] S_HWAIT = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] r_st, n_st;
    logic [1:0] r_ch, n_ch;
    logic [7:0] r_k, n_k;
    logic       r_base, n_base;

    always_comb begin
        n_st = r_st;
        n_ch = r_ch;
        n_k = r_k;
        n_base = r_base;
        o_cmd = '0;
        o_cmd.chan = r_ch;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_st)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_base = i_stat.baseline;
                    n_ch = 2'd0;
                    n_st = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_base) begin
                    n_ch = 2'd0;
                    n_st = S_HSUM;
                    o_cmd.hist_clr = 1'b1;
                    n_k = '0;
                end else if (i_stat.delta_zero) begin
                    n_st = S_CHK;
                end else begin
                    n_st = S_SDIV;
                end
            end
            S_SDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel = DIV_LOAD0 + {1'b0, r_ch};
                n_st = S_WDIV;
            end
            S_WDIV: if (!i_stat.div_busy) n_st = S_ACC;
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_st = S_CHK;
            end
            S_CHK: begin
                if (i_stat.close_due) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel = DIV_AVG0 + {1'b0, r_ch};
                    n_st = S_CWAIT;
                end else if (r_ch == 2'd2) begin
                    n_ch = 2'd0;
                    o_cmd.hist_clr = 1'b1;
                    n_st = S_HSUM;
                end else begin
                    n_ch = r_ch + 2'd1;
                    n_st = i_stat.delta_zero ? S_CHK : S_SDIV;
                end
            end
            S_CWAIT: if (!i_stat.div_busy) n_st = S_CLOSE;
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                if (r_ch == 2'd2) begin
                    n_ch = 2'd0;
                    o_cmd.hist_clr = 1'b1;
                    n_st = S_HSUM;
                end else begin
                    n_ch = r_ch + 2'd1;
                    n_st = i_stat.delta_zero ? S_CHK : S_SDIV;
                end
            end
            S_HSUM: begin
                if (r_k == i_stat.hist_n) begin
                    n_st = S_HDIV;
                end else begin
                    o_cmd.hist_step = 1'b1;
                    n_k = r_k + 8'd1;
                end
            end
            S_HDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel = DIV_HIST;
                n_st = S_HWAIT;
            end
            S_HWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.hist_avg = 1'b1;
                    n_k = '0;
                    if (r_ch == 2'd2) begin
                        n_st = S_DONE;
                    end else begin
                        n_ch = r_ch + 2'd1;
                        o_cmd.hist_clr = 1'b1;
                        n_st = S_HSUM;
                    end
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_st = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ch <= '0;
            r_k <= '0;
            r_base <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ch <= n_ch;
            r_k <= n_k;
            r_base <= n_base;
        end
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid together");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy) else $error("divider restarted");
    a_close_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.close |-> $past(i_stat.close_due, 2) || r_st == S_CLOSE)
        else $error("close without due window");
endmodule

### rtl/cpu_load_window_monitor_core.sv
// top level of the cpu load window monitor
// channel   dir  handshake      payload
// in_ch     in   valid/ready    counters, idle mask, time
// out_ch    out  valid/ready    loads, done flags, history averages, overload flags
// cfg_ch    in   valid/ready    register index, write data
// one item at a time; each item uses the shared divider up to nine times,
// plus history summation
// reset is synchronous and active low; no clearing pass
// input ready is low from acceptance until the result is taken
// configuration writes are always taken
module cpu_load_window_monitor_core #(
    parameter int unsigned HISTORY_DEPTH = clwm_pkg::HistDepthDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    clwm_in_if.sink    in_ch,
    clwm_out_if.source out_ch,
    clwm_cfg_if.sink   cfg_ch
);
    import clwm_pkg::*;
    t_cmd  w_cmd;
    t_stat w_stat;

    assign cfg_ch.ready = 1'b1;

    clwm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    clwm_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_item(in_ch.data),
        .i_cfg_we(cfg_ch.valid), .i_cfg_idx(cfg_ch.index),
        .i_cfg_data(cfg_ch.wdata), .o_stat(w_stat), .o_res(out_ch.data)
    );
endmodule

### test/clwm_tb_if.sv
`timescale 1ns / 100ps
// testbench copy note: channel interfaces come from the rtl file; this file holds tb item types
package clwm_tb_pkg;
    import clwm_pkg::*;

    typedef struct {
        t_in_item  item;
        bit        has_exp;
        t_out_item exp;
    } t_stim_row;
endpackage

### test/cpu_load_window_monitor_core_tb.sv
`timescale 1ns / 100ps
// testbench: load monitor driven by directed and random samples, checked against a predictor
module cpu_load_window_monitor_core_tb;
    import clwm_pkg::*;
    import clwm_tb_pkg::*;

    localparam int unsigned HD = HistDepthDef;
    localparam int unsigned WdogLimit = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    clwm_in_if  in_ch ();
    clwm_out_if out_ch ();
    clwm_cfg_if cfg_ch ();

    cpu_load_window_monitor_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    bit [31:0] win_len [3];
    bit [31:0] min_samp;
    bit [31:0] thresh;
    bit        first_pending;
    bit [31:0] last_total;
    bit [31:0] last_idle [2];
    bit [31:0] acc_sum [3];
    bit [31:0] acc_cnt [3];
    bit [31:0] win_start [3];
    bit [6:0]  load_now [3];
    bit        done_flag [3];
    bit [6:0]  hist [3][HD];
    bit [31:0] hist_ptr [3];
    bit        hist_full [3];

    t_out_item load_expect_q[$];
    int unsigned mismatch_cnt;
    bit          timed_out;
    bit          tail_quiet;
    int unsigned quiet_cycles;

    function automatic void model_reset();
        win_len[0] = 600; win_len[1] = 50; win_len[2] = 600;
        min_samp = 1; thresh = 80;
        first_pending = 1'b1; last_total = '0;
        for (int c = 0; c < 3; c++) begin
            acc_sum[c] = '0; acc_cnt[c] = '0; win_start[c] = '0;
            load_now[c] = '0; done_flag[c] = 1'b0;
            hist_ptr[c] = '0; hist_full[c] = 1'b0;
            for (int k = 0; k < HD; k++) hist[c][k] = '0;
        end
        last_idle[0] = '0; last_idle[1] = '0;
    endfunction

    function automatic void model_config(logic [CfgIdxW-1:0] idx, bit [31:0] v);
        case (idx)
            CFG_CORE0_WIN: win_len[0] = v;
            CFG_CORE1_WIN: win_len[1] = v;
            CFG_SYS_WIN:   win_len[2] = v;
            CFG_MIN_SAMP:  min_samp = {16'd0, v[15:0]};
            CFG_THRESH:    thresh = {25'd0, v[6:0]};
            default: ;
        endcase
    endfunction

    function automatic void try_close(int c, bit [31:0] now);
        bit [31:0] dur;
        bit [31:0] avg;
        bit [31:0] p;
        dur = now - win_start[c];
        if (dur < win_len[c] || acc_cnt[c] == 0 || acc_cnt[c] < min_samp) return;
        avg = acc_sum[c] / acc_cnt[c];
        load_now[c] = (avg > 100) ? 7'd100 : avg[6:0];
        acc_sum[c] = '0; acc_cnt[c] = '0; win_start[c] = now;
        done_flag[c] = 1'b1;
        p = hist_ptr[c] % HD;
        hist[c][p] = load_now[c];
        p = (p + 1) % HD;
        hist_ptr[c] = p;
        if (p == 0) hist_full[c] = 1'b1;
    endfunction

    function automatic bit [31:0] hist_mean(int c);
        bit [31:0] n;
        bit [31:0] s;
        n = hist_full[c] ? HD : hist_ptr[c];
        s = 0;
        if (n == 0) return 0;
        for (int k = 0; k < n; k++) s += hist[c][k];
        return s / n;
    endfunction

    function automatic t_out_item predict_load(t_in_item it);
        t_out_item r;
        bit [31:0] delta, idl, id;
        bit [63:0] idle_sum, work, poss, clip;
        bit [31:0] m [3];
        bit [31:0] idle_in [2];
        idle_in[0] = it.idle_count_core0;
        idle_in[1] = it.idle_count_core1;
        if (first_pending || last_total == 0) begin
            for (int c = 0; c < 2; c++)
                if (it.idle_found[c]) last_idle[c] = idle_in[c];
            first_pending = 1'b0;
        end else begin
            delta = it.total_run_time - last_total;
            idle_sum = 0;
            for (int c = 0; c < 2; c++) begin
                idl = it.idle_found[c] ? idle_in[c] : 32'd0;
                id = idl - last_idle[c];
                idle_sum += id;
                if (delta > 0) begin
                    work = (id <= delta) ? 64'(delta - id) : 64'd0;
                    acc_sum[c] += 32'((work * 100) / delta);
                    acc_cnt[c]++;
                end
                last_idle[c] = idl;
                try_close(c, it.time_ms);
            end
            if (delta > 0) begin
                poss = 64'(delta) * 2;
                clip = (idle_sum > poss) ? poss : idle_sum;
                acc_sum[2] += 32'(((poss - clip) * 100) / poss);
                acc_cnt[2]++;
            end
            try_close(2, it.time_ms);
        end
        last_total = it.total_run_time;
        for (int c = 0; c < 3; c++) m[c] = hist_mean(c);
        r.c0_load_pct = load_now[0]; r.c1_load_pct = load_now[1];
        r.sys_load_pct = load_now[2];
        r.core0_window_done = done_flag[0];
        r.core1_window_done = done_flag[1];
        r.system_window_done = done_flag[2];
        r.core0_history_avg = m[0][6:0];
        r.core1_history_avg = m[1][6:0];
        r.system_history_avg = m[2][6:0];
        r.core0_overload = m[0] >= thresh;
        r.core1_overload = m[1] >= thresh;
        r.system_overload = m[2] >= thresh;
        return r;
    endfunction

    function automatic t_in_item mk(bit [31:0] tot, bit [31:0] i0, bit [31:0] i1,
                                    bit [1:0] f, bit [31:0] t);
        t_in_item it;
        it.total_run_time = tot; it.idle_count_core0 = i0; it.idle_count_core1 = i1;
        it.idle_found = f; it.time_ms = t;
        return it;
    endfunction

    // result checking
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (load_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected item %h", out_ch.data);
            end else begin
                want = load_expect_q.pop_front();
                if (out_ch.data !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch exp %h got %h", want, out_ch.data);
                end
            end
        end
    end

    // sink stalls
    initial begin
        int unsigned n;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!tail_quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WdogLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_load(t_in_item it, bit has_exp, t_out_item exp);
        t_out_item p;
        int unsigned n;
        n = 1;
        if (!tail_quiet && $urandom_range(0, 3) == 0) n = $urandom_range(1, 12);
        repeat (n) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        p = predict_load(it);
        if (has_exp && p !== exp) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("table row exp %h predictor %h", exp, p);
        end
        load_expect_q.push_back(has_exp ? exp : p);
        do @(posedge i_clk); while (!in_ch.ready);
        in_ch.valid <= 1'b0;
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, bit [31:0] v);
        while (load_expect_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= v;
        model_config(idx, v);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        t_stim_row rows[$];
        t_stim_row r;
        t_out_item z;
        bit [31:0] tot, i0, i1, tm, d;
        int unsigned phase;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_CORE0_WIN;
        cfg_ch.wdata = '0;
        mismatch_cnt = 0; timed_out = 0; tail_quiet = 0; quiet_cycles = 0;
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        z = '0;
        // baseline sample right after reset gives all zeros
        r.item = mk(32'd1000, 32'd10, 32'd20, 2'b11, 32'd0); r.has_exp = 1; r.exp = z;
        rows.push_back(r);
        r.has_exp = 0;
        r.item = mk(32'd2000, 32'd510, 32'd20, 2'b11, 32'd100); rows.push_back(r);
        r.item = mk(32'd2000, 32'd600, 32'd30, 2'b11, 32'd100); rows.push_back(r);
        r.item = mk(32'd3000, 32'd5000, 32'd1, 2'b01, 32'd700); rows.push_back(r);
        r.item = mk(32'd4000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b10, 32'd800); rows.push_back(r);
        r.item = mk(32'd0, 32'd0, 32'd0, 2'b00, 32'd900); rows.push_back(r);
        r.item = mk(32'd5, 32'd1, 32'd1, 2'b11, 32'd950); rows.push_back(r);
        r.item = mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 2'b11, 32'hFFFF_FFFF);
        rows.push_back(r);
        r.item = mk(32'd3, 32'd2, 32'd4, 2'b11, 32'd500); rows.push_back(r);
        for (int k = 0; k < 10; k++) begin
            r.item = mk(32'd100 * (k + 4), 32'd7 * k, 32'd30 * k, 2'($urandom),
                        32'd700 + 32'd650 * k);
            rows.push_back(r);
        end
        foreach (rows[k]) send_load(rows[k].item, rows[k].has_exp, rows[k].exp);

        tot = 32'd50000; i0 = 0; i1 = 0; tm = 32'd20000;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                1: begin
                    write_reg(CFG_CORE0_WIN, 32'd1); write_reg(CFG_CORE1_WIN, 32'd1);
                    write_reg(CFG_SYS_WIN, 32'd1); write_reg(CFG_MIN_SAMP, 32'd0);
                    write_reg(CFG_THRESH, 32'd0);
                end
                2: begin
                    write_reg(CFG_CORE0_WIN, 32'd30); write_reg(CFG_CORE1_WIN, 32'd10);
                    write_reg(CFG_SYS_WIN, 32'd50); write_reg(CFG_MIN_SAMP, 32'd3);
                    write_reg(CFG_THRESH, 32'd50);
                end
                3: begin
                    write_reg(CFG_CORE0_WIN, 32'hFFFF_FFFF);
                    write_reg(CFG_MIN_SAMP, 32'hFFFF); write_reg(CFG_THRESH, 32'd100);
                end
                4: begin
                    write_reg(CFG_CORE0_WIN, 32'd5); write_reg(CFG_MIN_SAMP, 32'd1);
                    write_reg(CFG_THRESH, 32'h7F); write_reg(CFG_SYS_WIN, 32'd20);
                end
                5: begin
                    write_reg(CFG_THRESH, 32'd40);
                    tail_quiet = 1'b1;
                end
                default: ;
            endcase
            for (int k = 0; k < 320; k++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        tot = $urandom; i0 = $urandom; i1 = $urandom; tm = $urandom;
                    end
                    1: tm += $urandom_range(0, 3);
                    default: begin
                        d = $urandom_range(0, 2000);
                        tot += d;
                        i0 += $urandom_range(0, d + 200);
                        i1 += $urandom_range(0, d + 200);
                        tm += $urandom_range(1, 40);
                    end
                endcase
                z = '0;
                send_load(mk(tot, i0, i1, ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'b11,
                             tm), 1'b0, z);
            end
        end

        while (load_expect_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
